@@ rtl/mhpr_pkg.sv @@
// ----------------------------------------------------------------------------
// mhpr_pkg
// Shared constants, types and helpers for the masked histogram peak ratio.
// ----------------------------------------------------------------------------
package mhpr_pkg;

    localparam int LEVELS    = 256;
    localparam int PIXEL_W   = 8;
    localparam int COUNT_W   = 21;
    localparam int LEVEL_AW  = $clog2(LEVELS);
    localparam int FRAC_W    = 16;
    localparam int RATIO_W   = FRAC_W + 1;
    localparam int DIV_STEPS = RATIO_W;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [RATIO_W-1:0] ONE_Q16   = RATIO_W'(1) << FRAC_W;

    typedef enum logic [5:0] {
        ST_INIT   = 6'b000001,
        ST_ACCUM  = 6'b000010,
        ST_FLUSH  = 6'b000100,
        ST_SCAN   = 6'b001000,
        ST_SETTLE = 6'b010000,
        ST_DIV    = 6'b100000
    } mhpr_state_t;

    typedef struct packed {
        logic                accum;
        logic                sweep;
        logic                scan;
        logic                best_clr;
        logic                div_step;
        logic                div_first;
        logic                load;
        logic [LEVEL_AW-1:0] addr;
    } mhpr_cmd_t;

    typedef struct packed {
        logic out_full;
    } mhpr_status_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + COUNT_W'(1);
    endfunction

endpackage

@@ rtl/mhpr_ram.sv @@
// ----------------------------------------------------------------------------
// mhpr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mhpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/mhpr_ctrl.sv @@
// ----------------------------------------------------------------------------
// mhpr_ctrl
// Frame sequencer: clear sweep, accumulate, bin scan, divide and result load.
// ----------------------------------------------------------------------------
module mhpr_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  last,
    output logic                  in_ready,
    input  mhpr_pkg::mhpr_status_t status,
    output mhpr_pkg::mhpr_cmd_t    cmd
);

    localparam logic [mhpr_pkg::LEVEL_AW-1:0] LAST_ADDR =
        mhpr_pkg::LEVEL_AW'(mhpr_pkg::LEVELS - 1);
    localparam logic [mhpr_pkg::DIV_CW-1:0] DIV_LAST =
        mhpr_pkg::DIV_CW'(mhpr_pkg::DIV_STEPS - 1);

    mhpr_pkg::mhpr_state_t state_reg, state_next;
    logic [mhpr_pkg::LEVEL_AW-1:0] addr_reg, addr_next;
    logic [mhpr_pkg::DIV_CW-1:0]   div_cnt_reg, div_cnt_next;
    logic                          done_reg, done_next;

    always_comb
    begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        div_cnt_next  = div_cnt_reg;
        done_next     = done_reg;
        in_ready      = 1'b0;
        cmd           = '0;
        cmd.addr      = addr_reg;
        case (state_reg)
            mhpr_pkg::ST_INIT:
            begin
                cmd.sweep = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == LAST_ADDR)
                begin
                    addr_next  = '0;
                    state_next = mhpr_pkg::ST_ACCUM;
                end
            end
            mhpr_pkg::ST_ACCUM:
            begin
                // hold off a new frame only while its predecessor's result is pending
                if (done_reg)
                begin
                    if (!status.out_full)
                    begin
                        cmd.load  = 1'b1;
                        done_next = 1'b0;
                    end
                end
                else
                begin
                    in_ready  = 1'b1;
                    cmd.accum = in_valid;
                    if (in_valid && last)
                    begin
                        state_next = mhpr_pkg::ST_FLUSH;
                    end
                end
            end
            mhpr_pkg::ST_FLUSH:
            begin
                cmd.best_clr = 1'b1;
                state_next   = mhpr_pkg::ST_SCAN;
            end
            mhpr_pkg::ST_SCAN:
            begin
                cmd.sweep = 1'b1;
                cmd.scan  = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == LAST_ADDR)
                begin
                    addr_next  = '0;
                    state_next = mhpr_pkg::ST_SETTLE;
                end
            end
            mhpr_pkg::ST_SETTLE:
            begin
                div_cnt_next = '0;
                state_next   = mhpr_pkg::ST_DIV;
            end
            mhpr_pkg::ST_DIV:
            begin
                cmd.div_step  = 1'b1;
                cmd.div_first = (div_cnt_reg == '0);
                div_cnt_next  = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_LAST)
                begin
                    done_next  = 1'b1;
                    state_next = mhpr_pkg::ST_ACCUM;
                end
            end
            default:
            begin
                state_next = mhpr_pkg::ST_INIT;
                addr_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= mhpr_pkg::ST_INIT;
            addr_reg    <= '0;
            div_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            div_cnt_reg <= div_cnt_next;
            done_reg    <= done_next;
        end
    end

    a_no_accept_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !in_ready)
        else $error("pixel taken while a result is pending");

    a_div_runs_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mhpr_pkg::ST_DIV && div_cnt_reg != DIV_LAST)
            |=> state_reg == mhpr_pkg::ST_DIV)
        else $error("divide left early");

    a_load_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> done_reg && !status.out_full)
        else $error("result load without a finished frame");

endmodule

@@ rtl/mhpr_dp.sv @@
// ----------------------------------------------------------------------------
// mhpr_dp
// Histogram memory with read-modify-write pipe, peak scan, restoring divider
// and output register.
// ----------------------------------------------------------------------------
module mhpr_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mhpr_pkg::mhpr_cmd_t               cmd,
    output mhpr_pkg::mhpr_status_t            status,
    input  logic [mhpr_pkg::PIXEL_W-1:0]      pixel,
    input  logic                              in_region,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [mhpr_pkg::COUNT_W-1:0]      peak_count,
    output logic [mhpr_pkg::PIXEL_W-1:0]      peak_level,
    output logic [mhpr_pkg::COUNT_W-1:0]      total_count,
    output logic [mhpr_pkg::RATIO_W-1:0]      ratio,
    output logic                              empty_res
);

    localparam int AW = mhpr_pkg::LEVEL_AW;
    localparam int CW = mhpr_pkg::COUNT_W;
    localparam int RW = mhpr_pkg::RATIO_W;

    logic          in_range;
    logic [AW-1:0] pix_addr;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [CW-1:0] ram_wdata, ram_rdata;

    logic          s1_valid_reg, s1_valid_next;
    logic [AW-1:0] s1_addr_reg;
    logic          fwd_reg, fwd_next;
    logic [CW-1:0] wr_data_reg;
    logic [CW-1:0] bin_cur, bin_inc;

    logic [CW-1:0] total_reg;
    logic          cmp_valid_reg;
    logic [AW-1:0] cmp_level_reg;
    logic [CW-1:0] best_count_reg;
    logic [AW-1:0] best_level_reg;

    logic [CW:0]   rem_reg, rem_in, rem_sub, rem_next;
    logic          rem_ge;
    logic [RW-1:0] quot_reg;

    logic          out_valid_reg;
    logic [CW-1:0] peak_count_reg, total_count_reg;
    logic [mhpr_pkg::PIXEL_W-1:0] peak_level_reg;
    logic [RW-1:0] ratio_reg;
    logic          empty_reg;
    logic          is_empty;

    assign in_range = {24'd0, pixel} < 32'(mhpr_pkg::LEVELS);
    assign pix_addr = AW'(pixel);

    assign bin_cur  = fwd_reg ? wr_data_reg : ram_rdata;
    assign bin_inc  = mhpr_pkg::sat_inc(bin_cur);

    assign ram_we    = cmd.sweep | s1_valid_reg;
    assign ram_waddr = cmd.sweep ? cmd.addr : s1_addr_reg;
    assign ram_wdata = cmd.sweep ? '0 : bin_inc;
    assign ram_raddr = cmd.scan ? cmd.addr : pix_addr;

    mhpr_ram #(
        .WIDTH (CW),
        .DEPTH (mhpr_pkg::LEVELS)
    ) u_bins (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // a read issued under the write of the same bin sees the old word: forward
    assign s1_valid_next = cmd.accum & in_region & in_range;
    assign fwd_next      = cmd.accum & s1_valid_reg & (s1_addr_reg == pix_addr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_reg       <= 1'b0;
            cmp_valid_reg <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            fwd_reg       <= fwd_next;
            cmp_valid_reg <= cmd.scan;
            if (s1_valid_reg)
            begin
                total_reg <= mhpr_pkg::sat_inc(total_reg);
            end
            else if (cmd.load)
            begin
                total_reg <= '0;
            end
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg   <= pix_addr;
        cmp_level_reg <= cmd.addr;
        if (s1_valid_reg)
        begin
            wr_data_reg <= bin_inc;
        end
        if (cmd.best_clr)
        begin
            best_count_reg <= '0;
            best_level_reg <= '0;
        end
        else if (cmp_valid_reg && (ram_rdata > best_count_reg))
        begin
            best_count_reg <= ram_rdata;
            best_level_reg <= cmp_level_reg;
        end
    end

    assign rem_in   = cmd.div_first ? {1'b0, best_count_reg} : rem_reg;
    assign rem_ge   = rem_in >= {1'b0, total_reg};
    assign rem_sub  = rem_ge ? (rem_in - {1'b0, total_reg}) : rem_in;
    assign rem_next = {rem_sub[CW-1:0], 1'b0};

    always_ff @(posedge clk)
    begin
        if (cmd.div_step)
        begin
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[RW-2:0], rem_ge};
        end
    end

    assign is_empty = (total_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            empty_reg       <= is_empty;
            total_count_reg <= total_reg;
            peak_count_reg  <= is_empty ? '0 : best_count_reg;
            peak_level_reg  <= is_empty ? '0 : mhpr_pkg::PIXEL_W'(best_level_reg);
            ratio_reg       <= is_empty ? '0 : quot_reg;
        end
    end

    assign status.out_full = out_valid_reg;
    assign out_valid       = out_valid_reg;
    assign peak_count      = peak_count_reg;
    assign peak_level      = peak_level_reg;
    assign total_count     = total_count_reg;
    assign ratio           = ratio_reg;
    assign empty_res       = empty_reg;

    a_port_conflict: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.sweep && s1_valid_reg))
        else $error("bin update collides with sweep");

    a_ratio_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ratio_reg <= mhpr_pkg::ONE_Q16)
        else $error("ratio above one");

    a_peak_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> peak_count_reg <= total_count_reg)
        else $error("peak above total");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && empty_reg) |-> (peak_count_reg == '0 && ratio_reg == '0))
        else $error("empty frame with nonzero result");

endmodule

@@ rtl/masked_histogram_peak_ratio.sv @@
// ----------------------------------------------------------------------------
// masked_histogram_peak_ratio
// Peak bin, region total and peak/total fraction of a masked intensity
// histogram, one result per frame.
// ----------------------------------------------------------------------------
// Pixels are taken one per cycle while a frame streams in; the histogram
// sits in a single-port-write RAM updated by a two-stage read-modify-write
// pipe. After the pixel marked last, the block works on its own through a
// flush step, a scan that reads each bin and writes it back to zero, a
// settle step and a restoring divide; the next frame's first pixel is
// taken once the result is in the output register, which waits there as
// long as out_ready is low. If the previous result has not yet been taken
// when a new one is finished, pixel input stalls until it is. After reset,
// a sweep clears the histogram RAM before the first pixel is taken.
// ----------------------------------------------------------------------------
module masked_histogram_peak_ratio (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [mhpr_pkg::PIXEL_W-1:0] pixel,
    input  logic                         in_region,
    input  logic                         last,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [mhpr_pkg::COUNT_W-1:0] peak_count,
    output logic [mhpr_pkg::PIXEL_W-1:0] peak_level,
    output logic [mhpr_pkg::COUNT_W-1:0] total_count,
    output logic [mhpr_pkg::RATIO_W-1:0] ratio,
    output logic                         empty_res
);

    mhpr_pkg::mhpr_cmd_t    cmd;
    mhpr_pkg::mhpr_status_t status;

    mhpr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .last     (last),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    mhpr_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .pixel       (pixel),
        .in_region   (in_region),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .peak_count  (peak_count),
        .peak_level  (peak_level),
        .total_count (total_count),
        .ratio       (ratio),
        .empty_res   (empty_res)
    );

endmodule
